// ----- hdl/pc1sc_pkg.sv -----
// Shared constants and types for the PC1 stream cipher.
package pc1sc_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned NUM_WORDS = 8;
  localparam int unsigned RND_W = $clog2(NUM_WORDS);

  localparam logic [WORD_W-1:0] MUL_A = 16'd20021;
  localparam logic [WORD_W-1:0] MUL_B = 16'd346;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_KEY_HIGH    = 2'd0;
  localparam cfg_idx_t CFG_KEY_LOW     = 2'd1;
  localparam cfg_idx_t CFG_DECRYPT_MODE = 2'd2;

  typedef logic [WORD_W-1:0] word_t;

endpackage

// ----- hdl/pc1_stream_cipher.sv -----
// PC1 byte-stream cipher, 128-bit key, one shared round unit.
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_stall    | in_data_byte[7:0], in_first
//  out_    | output    | out_valid / out_stall  | out_byte[7:0]
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_index[1:0], cfg_data[63:0]
//
// Each byte is accepted, then runs 8 keystream rounds, one per cycle,
// through a single round unit (three constant multiplies, one three-input add).
// The result is registered on the last round; if the output register is
// still held by out_stall, the block waits there before finishing.
// in_stall is high from acceptance until the byte's result is loaded.
// Synchronous active-low reset: key 0, decrypt mode 1, working key and sums 0.
module pc1_stream_cipher
  import pc1sc_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_data_byte,
  input  logic           in_first,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  cfg_idx_t       cfg_index,
  input  logic [63:0]    cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT} state_t;

  state_t             state_r, state_nxt;
  logic [RND_W-1:0]   rnd_r, rnd_nxt;
  word_t              wk_r [NUM_WORDS];
  word_t              wk_nxt [NUM_WORDS];
  word_t              t_r, t_nxt;
  word_t              sa_r, sa_nxt;
  word_t              sb_r, sb_nxt;
  word_t              acc_r, acc_nxt;
  logic [7:0]         byte_r, byte_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [63:0]        key_high_r, key_low_r;
  logic               decrypt_r;

  logic               in_acc;
  logic               out_free;
  word_t              t_x, sb_j, sa_n, sb_n, t_n, acc_n, ks;
  logic [2*WORD_W-1:0] prod_sb, prod_sa, prod_t;
  logic [7:0]         res, upd_b;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

  // round unit
  always_comb begin
    t_x     = t_r ^ wk_r[rnd_r];
    sb_j    = sb_r + word_t'(rnd_r);
    prod_sb = sb_j * MUL_A;
    prod_sa = t_x * MUL_B;
    prod_t  = t_x * MUL_A;
    sa_n    = prod_sa[WORD_W-1:0];
    sb_n    = prod_sb[WORD_W-1:0] + sa_r + sa_n;
    t_n     = prod_t[WORD_W-1:0] + word_t'(1);
    acc_n   = acc_r ^ t_n ^ sb_n;
    ks      = (state_r == S_RUN) ? acc_n : acc_r;
    res     = byte_r ^ ks[15:8] ^ ks[7:0];
    upd_b   = decrypt_r ? res : byte_r;
  end

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    t_nxt         = t_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    acc_nxt       = acc_r;
    byte_nxt      = byte_r;
    out_byte_nxt  = out_byte_r;
    out_valid_nxt = out_valid_r && out_stall;
    for (int i = 0; i < NUM_WORDS; i++) begin
      wk_nxt[i] = wk_r[i];
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          byte_nxt  = in_data_byte;
          t_nxt     = '0;
          acc_nxt   = '0;
          rnd_nxt   = '0;
          state_nxt = S_RUN;
          if (in_first) begin
            for (int i = 0; i < NUM_WORDS / 2; i++) begin
              wk_nxt[i]     = key_high_r[63 - WORD_W*i -: WORD_W];
              wk_nxt[i + 4] = key_low_r[63 - WORD_W*i -: WORD_W];
            end
            sa_nxt = '0;
            sb_nxt = '0;
          end
        end
      end
      S_RUN: begin
        t_nxt   = t_n;
        sa_nxt  = sa_n;
        sb_nxt  = sb_n;
        acc_nxt = acc_n;
        rnd_nxt = rnd_r + RND_W'(1);
        if (rnd_r == RND_W'(NUM_WORDS - 1)) begin
          rnd_nxt = '0;
          if (out_free) begin
            out_byte_nxt  = res;
            out_valid_nxt = 1'b1;
            for (int i = 0; i < NUM_WORDS; i++) begin
              wk_nxt[i] = wk_r[i] ^ {upd_b, upd_b};
            end
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (out_free) begin
          out_byte_nxt  = res;
          out_valid_nxt = 1'b1;
          for (int i = 0; i < NUM_WORDS; i++) begin
            wk_nxt[i] = wk_r[i] ^ {upd_b, upd_b};
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
      out_byte_r  <= '0;
      sa_r        <= '0;
      sb_r        <= '0;
      key_high_r  <= '0;
      key_low_r   <= '0;
      decrypt_r   <= 1'b1;
      for (int i = 0; i < NUM_WORDS; i++) begin
        wk_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
      out_byte_r  <= out_byte_nxt;
      sa_r        <= sa_nxt;
      sb_r        <= sb_nxt;
      for (int i = 0; i < NUM_WORDS; i++) begin
        wk_r[i] <= wk_nxt[i];
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KEY_HIGH:     key_high_r <= cfg_data;
          CFG_KEY_LOW:      key_low_r  <= cfg_data;
          CFG_DECRYPT_MODE: decrypt_r  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    acc_r      <= acc_nxt;
    byte_r     <= byte_nxt;
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_RUN) && (rnd_r == '0))
    else $error("accepted transaction did not start rounds");

  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> $past(state_r == S_RUN || state_r == S_WAIT))
    else $error("result appeared without a byte in flight");

  a_idle_round_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (rnd_r == '0))
    else $error("round counter not cleared when idle");

  a_wait_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT) |-> out_valid && $past(out_valid))
    else $error("waiting with a free output register");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the PC1 byte-stream cipher.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pc1sc_pkg::*;

  // index past the last register; writes to it must be dropped
  localparam cfg_idx_t CFG_UNUSED = 2'd3;
  localparam int PHASES = 10;
  localparam int PHASE_BYTES = 130;

  // Tracks the cipher state and holds the bytes the block still owes us.
  class pc1_tracker;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic        decrypt;
    word_t       work_key [NUM_WORDS];
    word_t       sum_a;
    word_t       sum_b;
    logic [7:0]  expected_bytes [$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      key_high = '0;
      key_low = '0;
      decrypt = 1'b1;
      foreach (work_key[i]) work_key[i] = '0;
      sum_a = '0;
      sum_b = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [63:0] data);
      case (idx)
        CFG_KEY_HIGH:     key_high = data;
        CFG_KEY_LOW:      key_low = data;
        CFG_DECRYPT_MODE: decrypt = data[0];
        default: ;
      endcase
    endfunction

    function word_t next_keystream();
      word_t       t;
      word_t       acc;
      logic [31:0] w;
      t = '0;
      acc = '0;
      for (int j = 0; j < NUM_WORDS; j++) begin
        t = t ^ work_key[j];
        w = (32'(sum_b) + 32'(j)) * 32'(MUL_A) + 32'(sum_a);
        sum_b = w[15:0];
        w = 32'(t) * 32'(MUL_B);
        sum_a = w[15:0];
        sum_b = sum_b + sum_a;
        w = 32'(t) * 32'(MUL_A) + 32'd1;
        t = w[15:0];
        acc = acc ^ t ^ sum_b;
      end
      return acc;
    endfunction

    function void note_byte(logic [7:0] data, logic first);
      word_t      ks;
      logic [7:0] res;
      logic [7:0] fed;
      if (first) begin
        for (int i = 0; i < 4; i++) begin
          work_key[i]     = key_high[63-16*i -: 16];
          work_key[i + 4] = key_low[63-16*i -: 16];
        end
        sum_a = '0;
        sum_b = '0;
      end
      ks = next_keystream();
      res = data ^ ks[15:8] ^ ks[7:0];
      // key update always follows the plaintext side
      fed = decrypt ? res : data;
      foreach (work_key[i]) work_key[i] = work_key[i] ^ {fed, fed};
      expected_bytes.insert(expected_bytes.size(), res);
    endfunction

    task report(string msg);
      $display("ERROR @%0t ns: %s", $time, msg);
      mismatches++;
    endtask

    task check_byte(logic [7:0] got);
      logic [7:0] want;
      checked++;
      if (expected_bytes.size() == 0) begin
        report($sformatf("out_byte 0x%02h with no byte pending", got));
        return;
      end
      want = expected_bytes.pop_front();
      if (got !== want)
        report($sformatf("out_byte 0x%02h, expected 0x%02h", got, want));
    endtask

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_first;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_idx_t    cfg_index;
  logic [63:0] cfg_data;

  pc1_tracker tracker = new();

  bit stall_en;
  bit tx_gaps_en;
  int hold_cycles;
  int rx_burst;
  int bytes_sent;
  int messages;
  int cfg_writes;

  pc1_stream_cipher dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_first     (in_first),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("** pc1_stream_cipher: FAILED **");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    rx_burst = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (rx_burst > 0) begin
        out_stall <= 1'b1;
        rx_burst--;
      end else if (stall_en && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        rx_burst = $urandom_range(1, 10) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_byte(out_byte);
  end

  task automatic send_byte(logic [7:0] data, logic first);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_first <= first;
    do @(posedge clk); while (in_stall);
    tracker.note_byte(data, first);
    bytes_sent++;
  endtask

  task automatic tx_gap(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // hold the sender until every pending byte has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [63:0] data);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_message(int len, bit with_first);
    logic [7:0] data;
    logic       first;
    for (int k = 0; k < len; k++) begin
      if (tx_gaps_en && $urandom_range(0, 5) == 0)
        tx_gap($urandom_range(1, 10));
      case ($urandom_range(0, 15))
        0:       data = 8'h00;
        1:       data = 8'hFF;
        default: data = 8'($urandom_range(0, 255));
      endcase
      first = (k == 0) ? with_first : ($urandom_range(0, 19) == 0);
      send_byte(data, first);
    end
    messages++;
  endtask

  initial begin
    logic [63:0] kh;
    logic [63:0] kl;
    logic [63:0] mode_word;
    int          phase_start;
    int          wait_cycles;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_first = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_KEY_HIGH;
    cfg_data = '0;
    stall_en = 1'b0;
    tx_gaps_en = 1'b0;
    hold_cycles = 0;
    bytes_sent = 0;
    messages = 0;
    cfg_writes = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // bytes before any message start run on the cleared working key
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);

    cfg_write(CFG_KEY_HIGH, '1);
    cfg_write(CFG_KEY_LOW, '0);
    cfg_write(CFG_DECRYPT_MODE, 64'hFFFF_FFFF_FFFF_FFFE);  // encrypt, junk above bit 0
    cfg_write(CFG_UNUSED, 64'hA5A5_5A5A_0F0F_F0F0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);

    // new key mid-message: only the next message start picks it up
    cfg_write(CFG_KEY_HIGH, 64'h0123_4567_89AB_CDEF);
    cfg_write(CFG_KEY_LOW, 64'hFEDC_BA98_7654_3210);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b1);

    // mode flip mid-message, no reload
    cfg_write(CFG_DECRYPT_MODE, '1);
    send_byte(8'h81, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h01, 1'b0);

    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'hFE, 1'b0);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin kh = '0; kl = '0; end
        1: begin kh = '1; kl = '1; end
        2: begin kh = '1; kl = '0; end
        default: begin
          kh = {$urandom, $urandom};
          kl = {$urandom, $urandom};
        end
      endcase
      mode_word = {$urandom, $urandom};
      mode_word[0] = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
      cfg_write(CFG_KEY_HIGH, kh);
      cfg_write(CFG_KEY_LOW, kl);
      cfg_write(CFG_DECRYPT_MODE, mode_word);
      if ($urandom_range(0, 2) == 0)
        cfg_write(CFG_UNUSED, {$urandom, $urandom});

      stall_en = (phase != 2) && (phase != PHASES - 1);
      tx_gaps_en = (phase != 2) && (phase != PHASES - 1);
      // receiver goes quiet for a long stretch while the sender keeps pushing
      if (phase == 3)
        hold_cycles = 300;

      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        send_message($urandom_range(1, 40), $urandom_range(0, 9) != 0);
        if (phase == 6 && bytes_sent - phase_start > PHASE_BYTES / 2) begin
          drain();
          send_message($urandom_range(1, 10), 1'b0);
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (tracker.pending() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    while (tracker.pending() != 0)
      tracker.report($sformatf("byte 0x%02h never came out",
                               tracker.expected_bytes.pop_front()));

    $display("Ran %0d bytes in %0d messages through %0d register writes, both modes.",
             bytes_sent, messages, cfg_writes);
    $display("Checked %0d output bytes, %0d mismatches.", tracker.checked,
             tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("** pc1_stream_cipher: PASSED **");
    end else begin
      $display("** pc1_stream_cipher: FAILED **");
    end
    $finish;
  end

endmodule
